// ----- design/arpbw_pkg.sv -----
// Package for the ARP binding watch table: word types, event codes,
// controller/datapath command and status structs, default sizes.
// No dependencies; compile first.
package arpbw_pkg;

	localparam int TABLE_ROWS_DEF = 64;
	localparam int MAC_BYTES_DEF  = 8;
	localparam int ZONE_MAPS_DEF  = 4;

	localparam int LEN_W  = 4;   // clamped MAC length, 0..8
	localparam int SLOT_W = 6;   // reported slot width

	localparam logic [2:0] MIN_WATCHED_KIND = 3'd3;

	typedef enum logic [2:0] {
		EV_SKIPPED = 3'd0,
		EV_NO_ZONE = 3'd1,
		EV_KNOWN   = 3'd2,
		EV_NEW     = 3'd3,
		EV_CHANGED = 3'd4,
		EV_FULL    = 3'd5
	} event_t;

	typedef struct packed {
		logic [2:0]  entry_kind;
		logic [31:0] iface_index;
		logic [31:0] ip_address;
		logic [63:0] hw_address;
		logic [7:0]  hw_length;
		logic [31:0] now_seconds;
		logic        last_row;
	} in_item_t;

	typedef struct packed {
		logic [2:0]        event_res;
		logic [SLOT_W-1:0] slot;
		logic [SLOT_W-1:0] retired_slot;
		logic              table_changed;
		logic              last_result;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic classify;
		logic search_step;
		logic commit;
		logic retire;
		logic emit;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic skip;
		logic hit;
		logic search_end;
		logic retire_needed;
		logic out_free;
	} dp_stat_t;

	// config address width: 8-byte registers, at least two slots decoded
	function automatic int cfg_addr_w(input int maps);
		return $clog2(maps > 1 ? maps : 2) + 3;
	endfunction

endpackage

// ----- design/arpbw_chan_if.sv -----
// Valid/ready channel carrying one word of a given payload type.
// No dependencies; the payload type is set at instantiation.
interface arpbw_chan_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/arp_binding_watch_table.sv -----
// ARP binding watch table, top level.
// Words are handled one at a time: the block is ready for the next word in the cycle
// after the result register loads.
// Reset (arst_n, async): table empty, search limit 0, change flag 0, maps 0.
module arp_binding_watch_table import arpbw_pkg::*; #(
	parameter int TABLE_ROWS = TABLE_ROWS_DEF,
	parameter int MAC_BYTES  = MAC_BYTES_DEF,
	parameter int ZONE_MAPS  = ZONE_MAPS_DEF,
	localparam int CFG_AW = cfg_addr_w(ZONE_MAPS)
) (
	input  logic              clk,
	input  logic              arst_n,
	arpbw_chan_if.sink        item,
	arpbw_chan_if.source      result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [63:0]       pwdata,
	output logic [63:0]       prdata,
	output logic              pready
);
	// Map registers, 8 bytes apart: interface index in the upper half,
	// zone id in the lower half.
	logic [63:0] zone_map [ZONE_MAPS];

	dp_cmd_t   cmd;
	dp_stat_t  stat;
	in_item_t  item_word;
	out_item_t result_word;
	logic      result_valid;

	assign item_word = item.payload;

	arpbw_cfg #(
		.ZONE_MAPS (ZONE_MAPS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.zone_map (zone_map)
	);

	// Sequencer: idle/accept, classify (kind and zone), search,
	// commit (append or known/full), retire of a changed row, emit.
	arpbw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Row store and search: the row memory is read one address a cycle
	// with registered data, so a hit is seen in the cycle after its read.
	// Only rows below the search limit are visited; the limit catches up
	// with the row count on each last word of an ARP table.
	// The result register decouples the output side: a new word is taken
	// while a finished result still waits.
	arpbw_dp #(
		.TABLE_ROWS (TABLE_ROWS),
		.MAC_BYTES  (MAC_BYTES),
		.ZONE_MAPS  (ZONE_MAPS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_d    (item_word),
		.cmd       (cmd),
		.stat      (stat),
		.zone_map  (zone_map),
		.out_ready (result.ready),
		.out_valid (result_valid),
		.out_item  (result_word)
	);

	assign result.valid   = result_valid;
	assign result.payload = result_word;
endmodule

// ----- design/arpbw_cfg.sv -----
// APB-style register file for the interface-to-zone map entries.
// Depends on arpbw_pkg.
module arpbw_cfg import arpbw_pkg::*; #(
	parameter int ZONE_MAPS = ZONE_MAPS_DEF,
	localparam int CFG_AW = cfg_addr_w(ZONE_MAPS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [63:0]       pwdata,
	output logic [63:0]       prdata,
	output logic              pready,
	output logic [63:0]       zone_map [ZONE_MAPS]
);
	localparam int IW = CFG_AW - 3;

	logic [IW-1:0] idx;
	logic          in_range;
	logic          wr;
	logic [63:0]   zone_q [ZONE_MAPS];

	assign idx      = paddr[CFG_AW-1:3];
	assign in_range = ({1'b0, idx} < (IW+1)'(ZONE_MAPS));
	assign wr       = psel && penable && pwrite && in_range;
	assign pready   = 1'b1;
	assign prdata   = in_range ? zone_q[idx] : '0;
	assign zone_map = zone_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ZONE_MAPS; i++) begin
				zone_q[i] <= '0;
			end
		end else if (wr) begin
			zone_q[idx] <= pwdata;
		end
	end
endmodule

// ----- design/arpbw_ctrl.sv -----
// Controller FSM: sequences accept, classify, table search, commit,
// retire and result hand-off. Depends on arpbw_pkg.
module arpbw_ctrl import arpbw_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);
	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_CLASSIFY = 6'b000010,
		ST_SEARCH   = 6'b000100,
		ST_COMMIT   = 6'b001000,
		ST_RETIRE   = 6'b010000,
		ST_EMIT     = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CLASSIFY;
				end
			end
			ST_CLASSIFY: begin
				cmd.classify = 1'b1;
				state_d      = stat.skip ? ST_EMIT : ST_SEARCH;
			end
			ST_SEARCH: begin
				cmd.search_step = 1'b1;
				if (stat.hit || stat.search_end) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = stat.retire_needed ? ST_RETIRE : ST_EMIT;
			end
			ST_RETIRE: begin
				cmd.retire = 1'b1;
				state_d    = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command at once");

	a_retire_after_commit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.retire |-> $past(cmd.commit))
		else $error("retire without a preceding commit");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (state_q == ST_IDLE) && in_valid)
		else $error("word loaded outside idle");
endmodule

// ----- design/arpbw_dp.sv -----
// Datapath: item registers, zone lookup, row memories, search pointer,
// row count, change flag and the result register. Depends on arpbw_pkg.
module arpbw_dp import arpbw_pkg::*; #(
	parameter int TABLE_ROWS = TABLE_ROWS_DEF,
	parameter int MAC_BYTES  = MAC_BYTES_DEF,
	parameter int ZONE_MAPS  = ZONE_MAPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  in_item_t    item_d,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	input  logic [63:0] zone_map [ZONE_MAPS],
	input  logic        out_ready,
	output logic        out_valid,
	output out_item_t   out_item
);
	localparam int AW = $clog2(TABLE_ROWS);
	localparam int CW = $clog2(TABLE_ROWS + 1);
	localparam int MW = 8 * MAC_BYTES;

	typedef struct packed {
		logic [31:0]      ip;
		logic [31:0]      zone;
		logic [MW-1:0]    mac;
		logic [LEN_W-1:0] len;
	} row_t;

	row_t row_mem  [TABLE_ROWS];
	logic live_mem [TABLE_ROWS];

	// current item
	logic [2:0]       kind_q;
	logic [31:0]      iface_q;
	logic [31:0]      ip_q;
	logic [MW-1:0]    mac_q;
	logic [LEN_W-1:0] len_q;
	logic             last_q;
	logic [31:0]      zone_q;

	logic [LEN_W-1:0] len_d;
	logic [MW-1:0]    mac_d;
	logic [31:0]      zone_d;

	// search
	logic [CW-1:0] ptr_q;
	logic          pend_q;
	logic [AW-1:0] pend_addr_q;
	row_t          rd_row_q;
	logic          rd_live_q;
	logic          found_q;
	logic          differs_q;
	logic [AW-1:0] match_q;
	logic          more;
	logic          hit;

	// table state
	logic [CW-1:0] count_q;
	logic [CW-1:0] limit_q;
	logic          changed_q;
	logic          full;
	logic          known;
	logic          do_append;

	// result
	event_t        ev_q;
	logic [AW-1:0] slot_q;
	logic [AW-1:0] ret_q;
	logic          out_valid_q;
	out_item_t     out_item_q;

	// length clamp and masking of the MAC bytes
	assign len_d = (item_d.hw_length > 8'(MAC_BYTES)) ? LEN_W'(MAC_BYTES)
	                                                   : item_d.hw_length[LEN_W-1:0];
	always_comb begin
		mac_d = '0;
		for (int b = 0; b < MAC_BYTES; b++) begin
			if (LEN_W'(b) < len_d) begin
				mac_d[b*8 +: 8] = item_d.hw_address[b*8 +: 8];
			end
		end
	end

	// first map entry in register order wins
	always_comb begin
		zone_d = '0;
		for (int i = ZONE_MAPS - 1; i >= 0; i--) begin
			if (zone_map[i][63:32] == iface_q) begin
				zone_d = zone_map[i][31:0];
			end
		end
	end

	assign more      = (ptr_q < limit_q);
	assign hit       = pend_q && rd_live_q && (rd_row_q.zone == zone_q) &&
	                   (rd_row_q.ip == ip_q);
	assign full      = (count_q == CW'(TABLE_ROWS));
	assign known     = found_q && !differs_q;
	assign do_append = cmd.commit && !known && !full;

	assign stat.skip          = (kind_q < MIN_WATCHED_KIND) || (zone_d == '0);
	assign stat.hit           = hit;
	assign stat.search_end    = !pend_q && !more;
	assign stat.retire_needed = found_q && differs_q && !full;
	assign stat.out_free      = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= item_d.entry_kind;
			iface_q <= item_d.iface_index;
			ip_q    <= item_d.ip_address;
			mac_q   <= mac_d;
			len_q   <= len_d;
			last_q  <= item_d.last_row;
		end
		if (cmd.classify) begin
			zone_q <= zone_d;
			ev_q   <= (kind_q < MIN_WATCHED_KIND) ? EV_SKIPPED : EV_NO_ZONE;
			slot_q <= '0;
			ret_q  <= '0;
		end
		if (cmd.search_step) begin
			pend_addr_q <= ptr_q[AW-1:0];
			if (hit) begin
				match_q   <= pend_addr_q;
				differs_q <= (rd_row_q.len != len_q) || (rd_row_q.mac != mac_q);
			end
		end
		if (cmd.commit) begin
			if (known) begin
				ev_q   <= EV_KNOWN;
				slot_q <= match_q;
			end else if (full) begin
				ev_q <= EV_FULL;
			end else begin
				ev_q   <= found_q ? EV_CHANGED : EV_NEW;
				slot_q <= count_q[AW-1:0];
				ret_q  <= found_q ? match_q : '0;
			end
		end
		if (cmd.emit) begin
			out_item_q.event_res     <= ev_q;
			out_item_q.slot          <= SLOT_W'(slot_q);
			out_item_q.retired_slot  <= SLOT_W'(ret_q);
			out_item_q.table_changed <= last_q && changed_q;
			out_item_q.last_result   <= last_q;
		end
	end

	// row memory: one read port for the search, one write port for appends
	always_ff @(posedge clk) begin
		if (cmd.search_step && more) begin
			rd_row_q <= row_mem[ptr_q[AW-1:0]];
		end
		if (do_append) begin
			row_mem[count_q[AW-1:0]] <= '{ip: ip_q, zone: zone_q, mac: mac_q, len: len_q};
		end
	end

	// live bits; only rows below the search limit are ever read
	always_ff @(posedge clk) begin
		if (cmd.search_step && more) begin
			rd_live_q <= live_mem[ptr_q[AW-1:0]];
		end
		if (cmd.retire) begin
			live_mem[match_q] <= 1'b0;
		end else if (do_append) begin
			live_mem[count_q[AW-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= '0;
			pend_q      <= 1'b0;
			found_q     <= 1'b0;
			count_q     <= '0;
			limit_q     <= '0;
			changed_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.classify) begin
				ptr_q   <= '0;
				pend_q  <= 1'b0;
				found_q <= 1'b0;
			end else if (cmd.search_step) begin
				pend_q <= more;
				if (more) begin
					ptr_q <= ptr_q + 1'b1;
				end
				if (hit) begin
					found_q <= 1'b1;
				end
			end
			if (do_append) begin
				count_q   <= count_q + 1'b1;
				changed_q <= 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				if (last_q) begin
					changed_q <= 1'b0;
					limit_q   <= count_q;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_ROWS))
		else $error("row count beyond table size");

	a_limit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		limit_q <= count_q)
		else $error("search limit ahead of row count");

	a_retire_found: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.retire |-> (found_q && differs_q && $past(do_append)))
		else $error("retire without a changed match and append");
endmodule
